// File: hw/rtl/recent_serial_duplicate_filter_assert.svh
// ---------------------------------------------------------------------------
// recent serial duplicate filter assertion macros
// concurrent property wrappers clocked on the rising edge, disabled in reset
// ---------------------------------------------------------------------------
`ifndef RECENT_SERIAL_DUPLICATE_FILTER_ASSERT_SVH
`define RECENT_SERIAL_DUPLICATE_FILTER_ASSERT_SVH

// same-cycle implication
`define RSDF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rsdf assertion failed");

// next-cycle implication
`define RSDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rsdf assertion failed");

`endif

// File: hw/rtl/rsdf_pkg.sv
// ---------------------------------------------------------------------------
// rsdf_pkg
// shared widths and defaults of the recent serial duplicate filter
// ---------------------------------------------------------------------------
package rsdf_pkg;

  localparam int SerialW          = 32;
  localparam int CapW             = 7;
  localparam int WindowDepthDflt  = 64;
  localparam logic [CapW-1:0] CapResetVal = CapW'(50);

  typedef logic [SerialW-1:0] serial_t;
  typedef logic [CapW-1:0]    cap_t;

endpackage

// File: hw/rtl/recent_serial_duplicate_filter.sv
// ---------------------------------------------------------------------------
// recent serial duplicate filter
// rejects serial numbers already seen among the most recent accepted ones
// ---------------------------------------------------------------------------
// Takes one 32-bit serial per cycle unless in_stall_o is high and answers
// accepted=1 for a new serial (which is then appended to a first-in-first-out
// window, evicting the oldest entry once the window holds the programmed
// capacity) or accepted=0 for a duplicate. Throughput is one transfer per
// cycle while out_stall_i is low; the input is registered in serial_q and
// in_vld_q and the result in out_vld_q and accepted_q. The rate is set by
// the combinational parallel compare of the registered serial against every
// window entry, which are held in flip-flops. Capacity 0 acts as 1 and values
// above WINDOW_DEPTH act as WINDOW_DEPTH; writing the capacity register empties
// the window and may only be done while the block is idle.
// ---------------------------------------------------------------------------
`include "recent_serial_duplicate_filter_assert.svh"

module recent_serial_duplicate_filter #(
  parameter int WINDOW_DEPTH = rsdf_pkg::WindowDepthDflt
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  rsdf_pkg::cap_t                     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [rsdf_pkg::SerialW-1:0] serial_number_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               accepted_o
);

  localparam int PtrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int ExtW = (CntW > rsdf_pkg::CapW) ? CntW : rsdf_pkg::CapW;
  localparam int SumW = ((PtrW > CntW) ? PtrW : CntW) + 1;

  rsdf_pkg::serial_t        entry_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  valid_q, valid_d;
  logic [PtrW-1:0]          oldest_q, oldest_d;
  logic [CntW-1:0]          fill_q, fill_d;
  rsdf_pkg::cap_t           cap_q;

  logic                     in_vld_q;
  rsdf_pkg::serial_t        serial_q;
  logic                     out_vld_q;
  logic                     accepted_q;

  logic [WINDOW_DEPTH-1:0]  hit_vec;
  logic                     match;
  logic                     advance;
  logic                     wr_en;
  logic [ExtW-1:0]          cap_ext, eff_cap, fill_ext;
  logic                     full;
  logic [SumW-1:0]          slot_sum;
  logic [PtrW-1:0]          slot;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  // effective capacity
  assign cap_ext  = ExtW'(cap_q);
  assign fill_ext = ExtW'(fill_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = ExtW'(1);
    end else if (cap_ext > ExtW'(WINDOW_DEPTH)) begin
      eff_cap = ExtW'(WINDOW_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (fill_ext >= eff_cap);

  // parallel compare
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      hit_vec[i] = valid_q[i] && (entry_q[i] == serial_q);
    end
  end
  assign match = |hit_vec;

  // append slot, oldest plus fill modulo depth
  always_comb begin
    slot_sum = SumW'(oldest_q) + SumW'(fill_q);
    if (slot_sum >= SumW'(WINDOW_DEPTH)) begin
      slot_sum = slot_sum - SumW'(WINDOW_DEPTH);
    end
  end
  assign slot = slot_sum[PtrW-1:0];

  always_comb begin
    valid_d  = valid_q;
    oldest_d = oldest_q;
    fill_d   = fill_q;
    wr_en    = 1'b0;
    if (cfg_we_i) begin
      valid_d  = '0;
      oldest_d = '0;
      fill_d   = '0;
    end else if (advance && !match) begin
      wr_en = 1'b1;
      if (full) begin
        valid_d[oldest_q] = 1'b0;
        if (oldest_q == PtrW'(WINDOW_DEPTH - 1)) begin
          oldest_d = '0;
        end else begin
          oldest_d = oldest_q + PtrW'(1);
        end
      end else begin
        fill_d = fill_q + CntW'(1);
      end
      valid_d[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      oldest_q   <= '0;
      fill_q     <= '0;
      cap_q      <= rsdf_pkg::CapResetVal;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        accepted_q <= !match;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      serial_q <= unsigned'(serial_number_i);
    end
    if (wr_en) begin
      entry_q[slot] <= serial_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign accepted_o  = accepted_q;

  `RSDF_ASSERT_IMPL(a_fill_le_cap, clk_i, rst_ni, 1'b1, fill_ext <= eff_cap)
  `RSDF_ASSERT_IMPL(a_valid_count, clk_i, rst_ni, 1'b1, $countones(valid_q) == fill_q)
  `RSDF_ASSERT_NEXT(a_dup_keeps_window, clk_i, rst_ni, advance && match && !cfg_we_i, $stable(valid_q) && $stable(fill_q))
  `RSDF_ASSERT_NEXT(a_new_is_accepted, clk_i, rst_ni, advance && !match, out_vld_q && accepted_q)

endmodule
